// ===== rtl/slotalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// slotalloc_pkg
// shared widths, codes and controller/datapath interface types of the
// slot allocator
// ----------------------------------------------------------------------------
package slotalloc_pkg;

    localparam int SLOT_COUNT_DEF = 8192;

    // field widths of the stream words
    localparam int ACT_W      = 2;
    localparam int SLOT_W     = 13;
    localparam int TIME_W     = 63;
    localparam int CNT_W      = 14;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 48;

    // slot table entry: busy flag above the stamp
    localparam int TBL_W = TIME_W + 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_PURGE   = 2'd2,
        ACT_COUNT   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_PURGE,
        ST_PFIN
    } state_t;

    typedef struct packed {
        logic accept;     // latch word, issue table reads
        logic clr_step;   // clear one slot table entry
        logic exec;       // commit alloc, release or count
        logic purge_step; // check one entry, read the next
        logic pfin;       // post the purge result
    } ctrl_cmd_t;

    typedef struct packed {
        logic idx_last;   // walk index at the last slot
        logic out_free;   // output register can take a word
    } dp_stat_t;

endpackage

// ===== rtl/slotalloc_ram.sv =====
// ----------------------------------------------------------------------------
// slotalloc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module slotalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/slotalloc_ctrl.sv =====
// ----------------------------------------------------------------------------
// slotalloc_ctrl
// sequencer: clearing pass, word accept, execute, purge walk
// ----------------------------------------------------------------------------
module slotalloc_ctrl
    import slotalloc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [ACT_W-1:0]   s_tuser,
    input  dp_stat_t           stat,
    output ctrl_cmd_t          cmd
);

    state_t  state_reg;
    state_t  state_next;
    action_t in_act;

    assign in_act = action_t'(s_tuser);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (in_act == ACT_PURGE) ? ST_PURGE : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PURGE:
            begin
                if (stat.idx_last)
                begin
                    state_next = ST_PFIN;
                end
            end
            ST_PFIN:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.exec = stat.out_free;
            end
            ST_PURGE:
            begin
                cmd.purge_step = 1'b1;
            end
            ST_PFIN:
            begin
                cmd.pfin = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/slotalloc_dp.sv =====
// ----------------------------------------------------------------------------
// slotalloc_dp
// free stack, slot table, counters and output register
// ----------------------------------------------------------------------------
module slotalloc_dp
    import slotalloc_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [ACT_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] N_C    = CW'(SLOT_COUNT);
    localparam logic [IW-1:0] LAST_C = IW'(SLOT_COUNT - 1);

    // input word fields
    action_t           in_act;
    logic [SLOT_W-1:0] in_slot;
    logic [TIME_W-1:0] in_treq;
    logic [TIME_W-1:0] in_now;

    assign in_act  = action_t'(s_tuser);
    assign in_slot = s_tdata[SLOT_W-1:0];
    assign in_treq = s_tdata[SLOT_W +: TIME_W];
    assign in_now  = s_tdata[SLOT_W+TIME_W +: TIME_W];

    // state registers
    logic [CW-1:0] depth_reg,   depth_next;
    logic [CW-1:0] low_reg,     low_next;    // lowest depth seen since reset
    logic [IW-1:0] evict_reg,   evict_next;
    logic [CW-1:0] total_reg,   total_next;
    logic [IW-1:0] idx_reg,     idx_next;
    logic [CW-1:0] removed_reg, removed_next;

    // held word
    action_t           act_reg,  act_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [TIME_W-1:0] treq_reg, treq_next;
    logic [TIME_W-1:0] now_reg,  now_next;

    // output register
    logic              oval_reg,    oval_next;
    logic [SLOT_W-1:0] ogrant_reg,  ogrant_next;
    logic              oevict_reg,  oevict_next;
    logic              ostat_reg,   ostat_next;
    logic [CNT_W-1:0]  oremove_reg, oremove_next;
    logic [CNT_W-1:0]  olive_reg,   olive_next;

    // ram ports
    logic              fl_we, fl_re;
    logic [IW-1:0]     fl_waddr, fl_raddr, fl_wdata, fl_rdata;
    logic              tb_we, tb_re;
    logic [IW-1:0]     tb_waddr, tb_raddr;
    logic [TBL_W-1:0]  tb_wdata, tb_rdata;

    // helpers
    logic              rd_busy;
    logic [TIME_W-1:0] rd_stamp;
    logic [CW-1:0]     total_dec;
    logic              push_ok;
    logic              pop;
    logic [IW-1:0]     pop_slot;
    logic [IW-1:0]     sel_slot;
    logic              rel_ok;
    logic              hit;
    logic              out_free;

    assign rd_busy   = tb_rdata[TBL_W-1];
    assign rd_stamp  = tb_rdata[TIME_W-1:0];
    assign total_dec = (total_reg != '0) ? total_reg - CW'(1) : total_reg;
    assign push_ok   = depth_reg != N_C;
    assign pop       = depth_reg != '0;
    // entries below the low mark were never written: they hold the reset order
    assign pop_slot  = (depth_reg == low_reg) ? IW'(N_C - depth_reg) : fl_rdata;
    assign sel_slot  = pop ? pop_slot : evict_reg;
    assign rel_ok    = (32'(slot_reg) < 32'(SLOT_COUNT)) && rd_busy;
    assign hit       = rd_busy && (rd_stamp < treq_reg);
    assign out_free  = !oval_reg || m_tready;

    assign stat.idx_last = idx_reg == LAST_C;
    assign stat.out_free = out_free;

    slotalloc_ram #(
        .WIDTH (IW),
        .DEPTH (SLOT_COUNT)
    ) u_free_ram (
        .clk   (clk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .re    (fl_re),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    slotalloc_ram #(
        .WIDTH (TBL_W),
        .DEPTH (SLOT_COUNT)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tb_we),
        .waddr (tb_waddr),
        .wdata (tb_wdata),
        .re    (tb_re),
        .raddr (tb_raddr),
        .rdata (tb_rdata)
    );

    // table reads
    always_comb
    begin
        fl_re    = cmd.accept && (in_act == ACT_ALLOC);
        fl_raddr = IW'(depth_reg - CW'(1));
        tb_re    = 1'b0;
        tb_raddr = IW'(in_slot);
        if (cmd.accept)
        begin
            tb_re = 1'b1;
            unique case (in_act)
                ACT_ALLOC:   tb_raddr = evict_reg;
                ACT_RELEASE: tb_raddr = IW'(in_slot);
                ACT_PURGE:   tb_raddr = '0;
                ACT_COUNT:   tb_raddr = '0;
                default:     tb_raddr = '0;
            endcase
        end
        else if (cmd.purge_step && !stat.idx_last)
        begin
            tb_re    = 1'b1;
            tb_raddr = idx_reg + IW'(1);
        end
    end

    // state updates, table writes, result
    always_comb
    begin
        depth_next   = depth_reg;
        low_next     = low_reg;
        evict_next   = evict_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        removed_next = removed_reg;
        act_next     = act_reg;
        slot_next    = slot_reg;
        treq_next    = treq_reg;
        now_next     = now_reg;
        oval_next    = oval_reg && !m_tready;
        ogrant_next  = ogrant_reg;
        oevict_next  = oevict_reg;
        ostat_next   = ostat_reg;
        oremove_next = oremove_reg;
        olive_next   = olive_reg;
        fl_we        = 1'b0;
        fl_waddr     = IW'(depth_reg);
        fl_wdata     = IW'(slot_reg);
        tb_we        = 1'b0;
        tb_waddr     = idx_reg;
        tb_wdata     = '0;

        if (cmd.clr_step)
        begin
            tb_we    = 1'b1;
            tb_waddr = idx_reg;
            tb_wdata = '0;
            idx_next = stat.idx_last ? '0 : idx_reg + IW'(1);
        end

        if (cmd.accept)
        begin
            act_next  = in_act;
            slot_next = in_slot;
            treq_next = in_treq;
            now_next  = in_now;
            if (in_act == ACT_PURGE)
            begin
                idx_next     = '0;
                removed_next = '0;
            end
        end

        if (cmd.exec)
        begin
            oval_next    = 1'b1;
            ogrant_next  = '0;
            oevict_next  = 1'b0;
            ostat_next   = 1'b0;
            oremove_next = '0;
            olive_next   = CNT_W'(total_reg);
            unique case (act_reg)
                ACT_ALLOC:
                begin
                    tb_we    = 1'b1;
                    tb_waddr = sel_slot;
                    tb_wdata = {1'b1, (treq_reg != '0) ? treq_reg : now_reg};
                    if (pop)
                    begin
                        depth_next = depth_reg - CW'(1);
                        if (depth_reg == low_reg)
                        begin
                            low_next = depth_reg - CW'(1);
                        end
                        total_next = total_reg + CW'(1);
                    end
                    else
                    begin
                        evict_next = (evict_reg == LAST_C) ? '0 : evict_reg + IW'(1);
                        total_next = (rd_busy ? total_dec : total_reg) + CW'(1);
                    end
                    ogrant_next = SLOT_W'(sel_slot);
                    oevict_next = !pop;
                    olive_next  = CNT_W'(total_next);
                end
                ACT_RELEASE:
                begin
                    if (rel_ok)
                    begin
                        tb_we      = 1'b1;
                        tb_waddr   = IW'(slot_reg);
                        tb_wdata   = {1'b0, rd_stamp};
                        total_next = total_dec;
                        if (push_ok)
                        begin
                            fl_we      = 1'b1;
                            fl_waddr   = IW'(depth_reg);
                            fl_wdata   = IW'(slot_reg);
                            depth_next = depth_reg + CW'(1);
                        end
                    end
                    ostat_next = !rel_ok;
                    olive_next = CNT_W'(total_next);
                end
                ACT_PURGE:
                begin
                    olive_next = CNT_W'(total_reg);
                end
                ACT_COUNT:
                begin
                    olive_next = CNT_W'(total_reg);
                end
                default:
                begin
                    olive_next = CNT_W'(total_reg);
                end
            endcase
        end

        if (cmd.purge_step)
        begin
            idx_next = stat.idx_last ? idx_reg : idx_reg + IW'(1);
            if (hit)
            begin
                tb_we        = 1'b1;
                tb_waddr     = idx_reg;
                tb_wdata     = {1'b0, rd_stamp};
                total_next   = total_dec;
                removed_next = removed_reg + CW'(1);
                if (push_ok)
                begin
                    fl_we      = 1'b1;
                    fl_waddr   = IW'(depth_reg);
                    fl_wdata   = idx_reg;
                    depth_next = depth_reg + CW'(1);
                end
            end
        end

        if (cmd.pfin)
        begin
            oval_next    = 1'b1;
            ogrant_next  = '0;
            oevict_next  = 1'b0;
            ostat_next   = 1'b0;
            oremove_next = CNT_W'(removed_reg);
            olive_next   = CNT_W'(total_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= N_C;
            low_reg     <= N_C;
            evict_reg   <= '0;
            total_reg   <= '0;
            idx_reg     <= '0;
            removed_reg <= '0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            depth_reg   <= depth_next;
            low_reg     <= low_next;
            evict_reg   <= evict_next;
            total_reg   <= total_next;
            idx_reg     <= idx_next;
            removed_reg <= removed_next;
            oval_reg    <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        slot_reg    <= slot_next;
        treq_reg    <= treq_next;
        now_reg     <= now_next;
        ogrant_reg  <= ogrant_next;
        oevict_reg  <= oevict_next;
        ostat_reg   <= ostat_next;
        oremove_reg <= oremove_next;
        olive_reg   <= olive_next;
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = {5'b0, olive_reg, oremove_reg, ostat_reg, oevict_reg, ogrant_reg};

endmodule

// ===== rtl/slot_allocator_fifo_evict.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_fifo_evict
// slot pool with a lifo free stack, fifo eviction and timed purge
// ----------------------------------------------------------------------------
// usage:
//   one command word on the s_ channel (s_tuser = action) gives exactly one
//   result word on the m_ channel. allocate pops the free stack, or evicts
//   the slot at the rotating cursor when the stack is empty; release frees
//   a busy slot; purge frees busy slots stamped before the cutoff; count
//   reports the live total
//   order: allocate, release and count latch the word and read the slot
//   table and free stack rams, then execute into the output register once
//   it is free; a new word is accepted only after that. purge walks the
//   slot table one entry per cycle, then posts its result; the next word
//   is accepted after the result is posted
//   reset: a clearing pass writes every slot table entry free with s_tready
//   low; the free stack needs no pass, unwritten entries read back in reset
//   order through a low-water mark
//   stall: the result sits in an output register; a new word is accepted
//   while it waits, and execution holds until the register frees up
// ----------------------------------------------------------------------------
module slot_allocator_fifo_evict
    import slotalloc_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // slot [12:0], time_req [75:13], now [138:76], zero [143:139]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action [1:0]
    input  logic [ACT_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // granted_slot [12:0], evicted [13], status [14], removed [28:15],
    // live_total [42:29], zero [47:43]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: clearing pass, accept, execute, purge walk
    slotalloc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // rams, counters and result register
    slotalloc_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while another is in flight");

    // a result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.pfin) |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // live total never exceeds the pool
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[42:29]) <= 32'(SLOT_COUNT)))
        else $error("live total above pool size");

    // an eviction is an allocate: no status, nothing removed
    a_evict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[13]) |-> (!m_tdata[14] && (m_tdata[28:15] == '0)))
        else $error("eviction word carries release or purge fields");

endmodule
